// ===== rtl/core/rpe_pkg.sv =====
// Rational polynomial evaluator: shared package.
// Holds the shared-unit operation codes and the request/response structs.
// No dependencies.
package rpe_pkg;

	localparam logic [1:0] OP_MUL = 2'd0;
	localparam logic [1:0] OP_DIV = 2'd1;
	localparam logic [1:0] OP_GCD = 2'd2;

	typedef struct packed {
		logic       start;
		logic [1:0] op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic wrap;
	} alu_rsp_t;

endpackage

// ===== rtl/core/rpe_alu.sv =====
// Rational polynomial evaluator: shared bit-serial arithmetic unit.
// One add/subtract datapath runs shift-add multiply, restoring divide and binary gcd.
// Depends on rpe_pkg.
module rpe_alu #(
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rpe_pkg::alu_req_t    req,
	input  logic [WORD_BITS-1:0] opa,
	input  logic [WORD_BITS-1:0] opb,
	output rpe_pkg::alu_rsp_t    rsp,
	output logic [WORD_BITS-1:0] res
);

	localparam int W  = WORD_BITS;
	localparam int CW = $clog2(W + 1);
	localparam logic [W-1:0] WSIGN = {1'b1, {(W-1){1'b0}}};

	logic          busy_q;
	logic          done_q;
	logic [1:0]    op_q;
	logic          gph_q;
	logic          neg_q;
	logic [W-1:0]  hi_q;
	logic [W-1:0]  lo_q;
	logic [W-1:0]  b_q;
	logic [CW-1:0] cnt_q;

	logic [W-1:0]  mag_a;
	logic [W-1:0]  mag_b;
	logic [W:0]    x_add;
	logic [W:0]    y_add;
	logic          sub;
	logic [W+1:0]  sum_w;
	logic          ge;
	logic          lo_zero;
	logic          b_zero;
	logic [W-1:0]  limit;

	assign mag_a   = opa[W-1] ? (~opa + W'(1)) : opa;
	assign mag_b   = opb[W-1] ? (~opb + W'(1)) : opb;
	assign lo_zero = (lo_q == '0);
	assign b_zero  = (b_q == '0);

	// shared adder
	always_comb begin
		x_add = {1'b0, lo_q};
		y_add = {1'b0, b_q};
		sub   = 1'b1;
		case (op_q)
			rpe_pkg::OP_MUL: begin
				x_add = {1'b0, hi_q};
				y_add = lo_q[0] ? {1'b0, b_q} : '0;
				sub   = 1'b0;
			end
			rpe_pkg::OP_DIV: begin
				x_add = {hi_q, lo_q[W-1]};
			end
			default: ;
		endcase
		sum_w = {1'b0, x_add} + {1'b0, (sub ? ~y_add : y_add)} + {{(W+1){1'b0}}, sub};
	end

	assign ge = sum_w[W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= rpe_pkg::OP_MUL;
			gph_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				gph_q  <= 1'b0;
			end else if (busy_q) begin
				case (op_q)
					rpe_pkg::OP_GCD: begin
						if (gph_q) begin
							if (cnt_q == '0) begin
								busy_q <= 1'b0;
								done_q <= 1'b1;
							end
						end else if (lo_zero || b_zero) begin
							gph_q <= 1'b1;
						end
					end
					default: begin
						if (cnt_q == CW'(1)) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			hi_q <= '0;
			if (req.op == rpe_pkg::OP_MUL) begin
				lo_q  <= mag_a;
				b_q   <= mag_b;
				cnt_q <= CW'(W);
				neg_q <= opa[W-1] ^ opb[W-1];
			end else begin
				lo_q  <= opa;
				b_q   <= opb;
				cnt_q <= (req.op == rpe_pkg::OP_GCD) ? '0 : CW'(W);
				neg_q <= 1'b0;
			end
		end else if (busy_q) begin
			case (op_q)
				rpe_pkg::OP_MUL: begin
					hi_q  <= sum_w[W:1];
					lo_q  <= {sum_w[0], lo_q[W-1:1]};
					cnt_q <= cnt_q - CW'(1);
				end
				rpe_pkg::OP_DIV: begin
					hi_q  <= ge ? sum_w[W-1:0] : x_add[W-1:0];
					lo_q  <= {lo_q[W-2:0], ge};
					cnt_q <= cnt_q - CW'(1);
				end
				rpe_pkg::OP_GCD: begin
					if (gph_q) begin
						if (cnt_q != '0) begin
							lo_q  <= {lo_q[W-2:0], 1'b0};
							cnt_q <= cnt_q - CW'(1);
						end
					end else if (lo_zero) begin
						lo_q <= b_q;
					end else if (b_zero) begin
						lo_q <= lo_q;
					end else if (!lo_q[0] && !b_q[0]) begin
						lo_q  <= {1'b0, lo_q[W-1:1]};
						b_q   <= {1'b0, b_q[W-1:1]};
						cnt_q <= cnt_q + CW'(1);
					end else if (!lo_q[0]) begin
						lo_q <= {1'b0, lo_q[W-1:1]};
					end else if (!b_q[0]) begin
						b_q <= {1'b0, b_q[W-1:1]};
					end else if (ge) begin
						lo_q <= sum_w[W-1:0];
					end else begin
						lo_q <= b_q;
						b_q  <= lo_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign limit    = neg_q ? WSIGN : (WSIGN - W'(1));
	assign rsp.done = done_q;
	assign rsp.wrap = (op_q == rpe_pkg::OP_MUL) && ((hi_q != '0) || (lo_q > limit));
	assign res      = ((op_q == rpe_pkg::OP_MUL) && neg_q) ? (~lo_q + W'(1)) : lo_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("done without a running operation");

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> (!busy_q && !done_q))
		else $error("start while unit busy");

endmodule

// ===== rtl/core/rational_polynomial_evaluator_core.sv =====
// Rational polynomial evaluator, top level: sequencer, state registers, stream ports.
// Per coefficient: four serial multiplies, a fifth for the next power unless the coefficient is last,
// a binary gcd and, when reducing, two serial divides.
// All through the one shared unit in rpe_alu.
// Not ready while an item is in work; a result waits in the output register.
// arst_n clears sequencer, accumulator, power (1) and point (1); no clearing pass needed.
module rational_polynomial_evaluator_core #(
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [WORD_BITS-1:0] cfg_wdata,   // eval_point
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [((2*WORD_BITS-1+7)/8)*8-1:0] s_tdata,   // coef_num, coef_den, zero pad
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [((2*WORD_BITS-1+7)/8)*8-1:0] m_tdata,   // sum_num, sum_den, zero pad
	output logic                 m_tuser      // overflow
);

	localparam int W      = WORD_BITS;
	localparam int TDATA_W = ((2*W-1+7)/8)*8;
	localparam int PAD_W  = TDATA_W - (2*W-1);
	localparam logic [W-1:0] WSIGN = {1'b1, {(W-1){1'b0}}};

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_M1   = 4'd1;
	localparam logic [3:0] S_M2   = 4'd2;
	localparam logic [3:0] S_M3   = 4'd3;
	localparam logic [3:0] S_M4   = 4'd4;
	localparam logic [3:0] S_ADD  = 4'd5;
	localparam logic [3:0] S_GCD  = 4'd6;
	localparam logic [3:0] S_CHK  = 4'd7;
	localparam logic [3:0] S_DN   = 4'd8;
	localparam logic [3:0] S_DD   = 4'd9;
	localparam logic [3:0] S_FIX  = 4'd10;
	localparam logic [3:0] S_PW   = 4'd11;
	localparam logic [3:0] S_OUT  = 4'd12;

	logic [3:0]   state_q;
	logic         pend_q;
	logic [W-1:0] rp_q;
	logic [W-1:0] acc_num_q;
	logic [W-1:0] acc_den_q;
	logic         wrap_q;
	logic [W-1:0] pt_q;
	logic         m_valid_q;

	logic [W-1:0] num_q;
	logic [W-2:0] den_q;
	logic         last_q;
	logic [W-1:0] t1_q;
	logic [W-1:0] t2_q;
	logic [W-1:0] t3_q;
	logic [W-1:0] out_num_q;
	logic [W-2:0] out_den_q;
	logic         out_ovf_q;

	rpe_pkg::alu_req_t alu_req;
	rpe_pkg::alu_rsp_t alu_rsp;
	logic [W-1:0] alu_a;
	logic [W-1:0] alu_b;
	logic [W-1:0] alu_res;
	logic [W-1:0] neg_res;
	logic [W-1:0] den_w;
	logic [W-1:0] neg_num;
	logic [W-1:0] neg_den;
	logic [W-1:0] neg_t1;
	logic [W-1:0] mag_num;
	logic [W-1:0] mag_den;
	logic [W-1:0] sum_add;
	logic         add_ovf;
	logic         op_state;
	logic         out_load;

	assign den_w   = {1'b0, den_q};
	assign neg_num = ~acc_num_q + W'(1);
	assign neg_den = ~acc_den_q + W'(1);
	assign neg_t1  = ~t1_q + W'(1);
	assign neg_res = ~alu_res + W'(1);
	assign mag_num = acc_num_q[W-1] ? neg_num : acc_num_q;
	assign mag_den = acc_den_q[W-1] ? neg_den : acc_den_q;
	assign sum_add = t1_q + t2_q;
	assign add_ovf = (t1_q[W-1] == t2_q[W-1]) && (sum_add[W-1] != t1_q[W-1]);

	assign op_state = (state_q == S_M1) || (state_q == S_M2) || (state_q == S_M3) ||
		(state_q == S_M4) || (state_q == S_GCD) || (state_q == S_DN) ||
		(state_q == S_DD) || (state_q == S_PW);

	always_comb begin
		alu_req.start = op_state && !pend_q;
		alu_req.op    = rpe_pkg::OP_MUL;
		alu_a         = '0;
		alu_b         = '0;
		case (state_q)
			S_M1: begin
				alu_a = rp_q;
				alu_b = num_q;
			end
			S_M2: begin
				alu_a = acc_num_q;
				alu_b = den_w;
			end
			S_M3: begin
				alu_a = acc_den_q;
				alu_b = t2_q;
			end
			S_M4: begin
				alu_a = acc_den_q;
				alu_b = den_w;
			end
			S_GCD: begin
				alu_req.op = rpe_pkg::OP_GCD;
				alu_a      = mag_num;
				alu_b      = mag_den;
			end
			S_DN: begin
				alu_req.op = rpe_pkg::OP_DIV;
				alu_a      = mag_num;
				alu_b      = t3_q;
			end
			S_DD: begin
				alu_req.op = rpe_pkg::OP_DIV;
				alu_a      = mag_den;
				alu_b      = t3_q;
			end
			S_PW: begin
				alu_a = rp_q;
				alu_b = pt_q;
			end
			default: ;
		endcase
	end

	rpe_alu #(
		.WORD_BITS(W)
	) u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.opa   (alu_a),
		.opb   (alu_b),
		.rsp   (alu_rsp),
		.res   (alu_res)
	);

	assign s_tready = (state_q == S_IDLE);
	assign out_load = (state_q == S_OUT) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pend_q    <= 1'b0;
			rp_q      <= W'(1);
			acc_num_q <= '0;
			acc_den_q <= W'(1);
			wrap_q    <= 1'b0;
			pt_q      <= W'(1);
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				pt_q <= cfg_wdata;
			end
			if (alu_req.start) begin
				pend_q <= 1'b1;
			end else if (alu_rsp.done) begin
				pend_q <= 1'b0;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (alu_rsp.done && alu_rsp.wrap) begin
				wrap_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) state_q <= S_M1;
				end
				S_M1: begin
					if (alu_rsp.done) state_q <= S_M2;
				end
				S_M2: begin
					if (alu_rsp.done) state_q <= S_M3;
				end
				S_M3: begin
					if (alu_rsp.done) state_q <= S_M4;
				end
				S_M4: begin
					if (alu_rsp.done) state_q <= S_ADD;
				end
				S_ADD: begin
					acc_num_q <= sum_add;
					acc_den_q <= t3_q;
					if (add_ovf) wrap_q <= 1'b1;
					state_q <= S_GCD;
				end
				S_GCD: begin
					if (alu_rsp.done) state_q <= S_CHK;
				end
				S_CHK: begin
					state_q <= (t3_q > W'(1)) ? S_DN : S_FIX;
				end
				S_DN: begin
					if (alu_rsp.done) state_q <= S_DD;
				end
				S_DD: begin
					if (alu_rsp.done) begin
						acc_num_q <= acc_num_q[W-1] ? neg_t1 : t1_q;
						acc_den_q <= acc_den_q[W-1] ? neg_res : alu_res;
						state_q   <= S_FIX;
					end
				end
				S_FIX: begin
					if (acc_den_q[W-1]) begin
						acc_den_q <= neg_den;
						acc_num_q <= neg_num;
						if ((acc_den_q == WSIGN) || (acc_num_q == WSIGN)) wrap_q <= 1'b1;
					end
					state_q <= last_q ? S_OUT : S_PW;
				end
				S_PW: begin
					if (alu_rsp.done) begin
						rp_q    <= alu_res;
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_load) begin
						rp_q      <= W'(1);
						acc_num_q <= '0;
						acc_den_q <= W'(1);
						wrap_q    <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			num_q  <= s_tdata[W-1:0];
			den_q  <= s_tdata[2*W-2:W];
			last_q <= s_tlast;
		end
		if (alu_rsp.done) begin
			case (state_q)
				S_M1:    t2_q <= alu_res;
				S_M2:    t1_q <= alu_res;
				S_M3:    t2_q <= alu_res;
				S_M4:    t3_q <= alu_res;
				S_GCD:   t3_q <= alu_res;
				S_DN:    t1_q <= alu_res;
				default: ;
			endcase
		end
		if (out_load) begin
			out_num_q <= acc_num_q;
			out_den_q <= acc_den_q[W-2:0];
			out_ovf_q <= wrap_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_den_q, out_num_q};
	assign m_tuser  = out_ovf_q;

	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> ($past(state_q) == S_OUT))
		else $error("result transfer raised outside emit state");

	a_done_pending: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> (pend_q && op_state))
		else $error("unit response with no request outstanding");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !s_tready)
		else $error("input ready while an operation is pending");

	a_den_positive: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_PW) || (state_q == S_OUT)) |-> (!acc_den_q[W-1] || wrap_q))
		else $error("negative denominator after sign fix without overflow");

endmodule
